// ----- src/mhpq_pkg.sv -----
// Shared codes and types for the min-heap priority queue.
package mhpq_pkg;

    // Command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Result control between sequencer and top level
    typedef struct packed {
        logic    done;
        t_status status;
    } t_res_ctl;

    // Fixed widths of the external fields
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

endpackage

// ----- src/mhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mhpq_seq.sv -----
// Heap sequencer: walks the moving key up or down the store with one shared comparator.
module mhpq_seq
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    parameter int IW        = $clog2(CAPACITY),
    parameter int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_command,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [INDEX_W-1:0]   i_remove_index,
    output logic                 o_busy,
    output logic                 o_we,
    output logic [IW-1:0]        o_waddr,
    output logic [KEY_WIDTH-1:0] o_wdata,
    output logic [IW-1:0]        o_raddr,
    input  logic [KEY_WIDTH-1:0] i_rdata,
    output t_res_ctl             o_res,
    output logic [CW-1:0]        o_count,
    output logic [KEY_WIDTH-1:0] o_min
);

    localparam int XW = CW + INDEX_W;
    localparam int LW = IW + 2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_UP_RD  = 8'b0000_0100,
        S_UP_CMP = 8'b0000_1000,
        S_DN_L   = 8'b0001_0000,
        S_DN_R   = 8'b0010_0000,
        S_DN_C   = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_i, n_i;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_best, n_best;
    logic                 r_took_l, n_took_l;
    logic                 r_rok, n_rok;
    logic                 r_cdown, n_cdown;
    t_status              r_status, n_status;
    logic [KEY_WIDTH-1:0] r_min;

    logic                 we;
    logic [IW-1:0]        waddr;
    logic [KEY_WIDTH-1:0] wdata;
    logic [IW-1:0]        raddr;

    logic [CW-1:0]        last;
    logic [IW-1:0]        parent;
    logic [LW-1:0]        l_ext, r_ext, cnt_ext;
    logic [XW-1:0]        idx_x, cnt_x;

    // Shared comparator: a < b, signed
    logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
    logic                        lt;

    assign last    = r_count - CW'(1);
    assign parent  = (r_i - IW'(1)) >> 1;
    assign l_ext   = {1'b0, r_i, 1'b1};
    assign r_ext   = l_ext + LW'(1);
    assign cnt_ext = {{(LW - CW){1'b0}}, r_count};
    assign idx_x   = {{(XW - INDEX_W){1'b0}}, i_remove_index};
    assign cnt_x   = {{(XW - CW){1'b0}}, r_count};

    // Steer comparator operands by step
    always_comb begin
        cmp_a = r_key;
        cmp_b = i_rdata;
        case (r_state)
            S_DN_R: begin
                cmp_a = i_rdata;
                cmp_b = r_key;
            end
            S_DN_C: begin
                cmp_a = i_rdata;
                cmp_b = r_best;
            end
            default: begin
                cmp_a = r_key;
                cmp_b = i_rdata;
            end
        endcase
    end

    assign lt = cmp_a < cmp_b;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_key    = r_key;
        n_best   = r_best;
        n_took_l = r_took_l;
        n_rok    = r_rok;
        n_cdown  = r_cdown;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_i;
        wdata    = r_key;
        raddr    = last[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_status = ST_OK;
                    if (i_command == CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_key   = i_key;
                            n_i     = r_count[IW-1:0];
                            n_count = r_count + CW'(1);
                            n_cdown = 1'b0;
                            n_state = S_UP_RD;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_FIN;
                    end else if (idx_x >= cnt_x) begin
                        n_status = ST_BAD_INDEX;
                        n_state  = S_FIN;
                    end else begin
                        // read the last entry while the count shrinks
                        n_i     = idx_x[IW-1:0];
                        n_count = last;
                        n_cdown = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_key = i_rdata;
                if (r_i == r_count[IW-1:0]) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                raddr = parent;
                if (r_i == '0) begin
                    if (r_cdown) begin
                        n_state = S_DN_L;
                    end else begin
                        we      = 1'b1;
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (lt) begin
                    // pull the parent down into the hole
                    we      = 1'b1;
                    wdata   = i_rdata;
                    n_i     = parent;
                    n_cdown = 1'b0;
                    n_state = S_UP_RD;
                end else if (r_cdown) begin
                    n_state = S_DN_L;
                end else begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_DN_L: begin
                raddr = l_ext[IW-1:0];
                if (l_ext >= cnt_ext) begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                raddr    = r_ext[IW-1:0];
                n_best   = lt ? i_rdata : r_key;
                n_took_l = lt;
                n_rok    = r_ext < cnt_ext;
                n_state  = S_DN_C;
            end
            S_DN_C: begin
                if (r_rok && lt) begin
                    we      = 1'b1;
                    wdata   = i_rdata;
                    n_i     = r_ext[IW-1:0];
                    n_state = S_DN_L;
                end else if (r_took_l) begin
                    we      = 1'b1;
                    wdata   = r_best;
                    n_i     = l_ext[IW-1:0];
                    n_state = S_DN_L;
                end else begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Datapath registers; track the root on every write to position zero
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_key    <= n_key;
        r_best   <= n_best;
        r_took_l <= n_took_l;
        r_rok    <= n_rok;
        r_cdown  <= n_cdown;
        r_status <= n_status;
        if (we && waddr == '0) begin
            r_min <= wdata;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_we         = we;
    assign o_waddr      = waddr;
    assign o_wdata      = wdata;
    assign o_raddr      = raddr;
    assign o_res.done   = (r_state == S_FIN);
    assign o_res.status = r_status;
    assign o_count      = r_count;
    assign o_min        = r_min;

endmodule

// ----- src/min_heap_priority_queue_top.sv -----
// Top level of the min-heap priority queue: store, sequencer and result register.
//
// Each command is taken when start is high and busy is low. It gives one result beat on
// o_valid in the cycle in which busy falls. The receiver cannot stall it, so o_valid is
// high for exactly one cycle. On an insert, the new key climbs the heap one level per read
// and compare of the parent. On a remove, the last entry is read into the vacated position,
// then climbs in the same way, or else descends one level per read of both children and
// compare; removing the last position needs no walk. The time a command takes is set by
// the single read port of the store (registered read) and by the one comparator that every
// step shares. Refused commands (full, empty, bad index) go straight to the finishing
// state and give their beat when busy falls. No clearing pass is needed after reset.
module min_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [INDEX_W-1:0] i_remove_index,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_entry_count_out,
    output logic [VALUE_W-1:0] o_min_value,
    output logic               o_min_valid
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + COUNT_W;

    logic                 accept;
    logic [2*VALUE_W-1:0] value_ext;
    logic [KEY_WIDTH-1:0] key_in;
    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    logic [KEY_WIDTH-1:0] wdata, rdata;
    t_res_ctl             res;
    logic [CW-1:0]        count;
    logic [KEY_WIDTH-1:0] min_key;
    logic [KEY_WIDTH+VALUE_W-1:0] min_ext;
    logic [XW-1:0]        count_x;

    logic                 r_valid;
    t_status              r_status;
    logic [COUNT_W-1:0]   r_count;
    logic [VALUE_W-1:0]   r_min;
    logic                 r_min_valid;

    assign accept    = start && !busy;
    // sign-extend the incoming value, then keep KEY_WIDTH bits
    assign value_ext = {{VALUE_W{i_value[VALUE_W-1]}}, i_value};
    assign key_in    = value_ext[KEY_WIDTH-1:0];
    assign min_ext   = {{VALUE_W{min_key[KEY_WIDTH-1]}}, min_key};
    assign count_x   = {{COUNT_W{1'b0}}, count};

    mhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mhpq_seq #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .IW        (IW),
        .CW        (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_key          (key_in),
        .i_remove_index (i_remove_index),
        .o_busy         (busy),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_res          (res),
        .o_count        (count),
        .o_min          (min_key)
    );

    // Hold the result beat for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.done;
        end
    end

    // Capture the result payload; root reads as zero when empty
    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_status    <= res.status;
            r_count     <= count_x[COUNT_W-1:0];
            r_min_valid <= (count != '0);
            r_min       <= (count != '0) ? min_ext[VALUE_W-1:0] : '0;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_entry_count_out = r_count;
    assign o_min_value       = r_min;
    assign o_min_valid       = r_min_valid;

    // A result beat never overlaps work on a command
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // An accepted command always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start");

    // Minimum is flagged exactly when entries are held
    a_min_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_valid == (o_entry_count_out != '0)))
        else $error("min_valid disagrees with count");

    // Count never exceeds the store
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({{CW{1'b0}}, o_entry_count_out} <= XW'(CAPACITY)))
        else $error("count beyond capacity");

endmodule

// ----- dv/tb_min_heap_priority_queue_top.sv -----
// Self-checking testbench for the min-heap priority queue: directed and random commands.
`timescale 1ns / 100ps

module tb_min_heap_priority_queue_top;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH  = 64;
    localparam int RANDOM_CMDS = 1000;
    localparam int IDLE_PCT    = 24;
    localparam int SETTLE_CYC  = 60;
    localparam int RUN_LIMIT   = 200000;

    // One command beat as the sender presents it
    typedef struct {
        t_cmd               cmd;
        logic [VALUE_W-1:0] key;
        logic [INDEX_W-1:0] pos;
        bit                 drain_first;
    } t_heap_cmd;

    // One result beat as the block reports it
    typedef struct {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] min_value;
        logic               min_valid;
    } t_heap_report;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic               i_command      = CMD_INSERT;
    logic [VALUE_W-1:0] i_value        = '0;
    logic [INDEX_W-1:0] i_remove_index = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_entry_count_out;
    logic [VALUE_W-1:0] o_min_value;
    logic               o_min_valid;

    // Shadow heap kept by the predictor
    logic signed [VALUE_W-1:0] heap_keys [HEAP_DEPTH];
    int unsigned               heap_size = 0;

    t_heap_cmd    queued_cmds [$];
    t_heap_report due_reports [$];

    int error_count   = 0;
    int taken_count   = 0;
    int report_count  = 0;
    int insert_count  = 0;
    int remove_count  = 0;
    int peak_size     = 0;
    int status_hits [4];
    int cycle_count   = 0;
    bit drain_hold    = 1'b0;
    int shadow_size   = 0;

    min_heap_priority_queue_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_value           (i_value),
        .i_remove_index    (i_remove_index),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_entry_count_out (o_entry_count_out),
        .o_min_value       (o_min_value),
        .o_min_valid       (o_min_valid)
    );

    always #2 i_clk = ~i_clk;

    // Move an entry towards the root while it beats its parent
    function automatic void heap_raise(int slot);
        int parent;
        logic signed [VALUE_W-1:0] held;
        while (slot > 0) begin
            parent = (slot - 1) / 2;
            if (!(heap_keys[slot] < heap_keys[parent]))
                break;
            held              = heap_keys[slot];
            heap_keys[slot]   = heap_keys[parent];
            heap_keys[parent] = held;
            slot              = parent;
        end
    endfunction

    // Move an entry towards the leaves, taking the smaller child (left on a tie)
    function automatic void heap_lower(int slot);
        int left;
        int right;
        int pick;
        logic signed [VALUE_W-1:0] held;
        while (slot < heap_size) begin
            left  = 2 * slot + 1;
            right = 2 * slot + 2;
            pick  = slot;
            if (left < heap_size && heap_keys[left] < heap_keys[pick])
                pick = left;
            if (right < heap_size && heap_keys[right] < heap_keys[pick])
                pick = right;
            if (pick == slot)
                break;
            held            = heap_keys[slot];
            heap_keys[slot] = heap_keys[pick];
            heap_keys[pick] = held;
            slot            = pick;
        end
    endfunction

    // Apply one command to the shadow heap and return the report it owes
    function automatic t_heap_report heap_apply_command(t_cmd cmd, logic [VALUE_W-1:0] key,
                                                        logic [INDEX_W-1:0] pos);
        t_heap_report rep;
        int slot;
        int last;
        slot       = int'(pos);
        rep.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (heap_size >= HEAP_DEPTH) begin
                rep.status = ST_FULL;
            end else begin
                heap_keys[heap_size] = key;
                heap_size++;
                heap_raise(heap_size - 1);
            end
        end else if (heap_size == 0) begin
            rep.status = ST_EMPTY;
        end else if (slot >= heap_size) begin
            rep.status = ST_BAD_INDEX;
        end else begin
            last            = heap_size - 1;
            heap_keys[slot] = heap_keys[last];
            heap_size       = last;
            if (slot < heap_size) begin
                if (slot > 0 && heap_keys[slot] < heap_keys[(slot - 1) / 2])
                    heap_raise(slot);
                else
                    heap_lower(slot);
            end
        end
        rep.count     = heap_size[COUNT_W-1:0];
        rep.min_valid = (heap_size != 0);
        rep.min_value = (heap_size != 0) ? heap_keys[0] : '0;
        return rep;
    endfunction

    // Queue one command and track the occupancy it leaves behind
    task automatic queue_cmd(t_cmd cmd, logic [VALUE_W-1:0] key, logic [INDEX_W-1:0] pos,
                             bit drain_first);
        t_heap_cmd item;
        item.cmd         = cmd;
        item.key         = key;
        item.pos         = pos;
        item.drain_first = drain_first;
        queued_cmds.push_back(item);
        if (cmd == CMD_INSERT) begin
            if (shadow_size < HEAP_DEPTH)
                shadow_size++;
        end else if (shadow_size > 0 && int'(pos) < shadow_size) begin
            shadow_size--;
        end
    endtask

    // Keys: mostly full range, some tight clusters for duplicates, some extremes
    function automatic logic [VALUE_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 5)
            return $urandom;
        else if (sel <= 8)
            return VALUE_W'($signed($urandom_range(16)) - 8);
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Positions: mostly live slots, with root, last slot and out-of-range ones mixed in
    function automatic logic [INDEX_W-1:0] pick_pos(int live);
        int sel;
        sel = $urandom_range(99);
        if (live == 0 || sel >= 94)
            return INDEX_W'($urandom_range(HEAP_DEPTH - 1));
        else if (sel < 78)
            return INDEX_W'($urandom_range(live - 1));
        else if (sel < 86)
            return INDEX_W'(live - 1);
        else if (sel < 90)
            return '0;
        return INDEX_W'($urandom_range(HEAP_DEPTH - 1,
                                       live < HEAP_DEPTH ? live : HEAP_DEPTH - 1));
    endfunction

    // Build the stimulus, release reset, then wait for the block to drain
    initial begin
        int made;
        int mode;
        int span;
        int insert_pct;
        bit first_random;

        status_hits = '{default: 0};

        // Directed: empty removal, extremes, duplicates, every removal path
        queue_cmd(CMD_REMOVE, 32'h0, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd0, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd100, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd1, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd101, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd102, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd2, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd3, 6'd0, 1'b0);
        queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 6'd3, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h0, 6'd63, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h0, 6'd6, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h0, 6'd5, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h0, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'h7FFF_FFFF, 6'd63, 1'b0);
        queue_cmd(CMD_INSERT, 32'h8000_0000, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd5, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd5, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'd5, 6'd0, 1'b0);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd0, 1'b0);
        queue_cmd(CMD_REMOVE, 32'h0, 6'd1, 1'b0);

        // Random: fill, drain and mixed spans, the first two set to fill and then to drain
        made         = 0;
        span         = 0;
        first_random = 1'b1;
        while (made < RANDOM_CMDS) begin
            if (made == 0)
                mode = 0;
            else if (made == 100)
                mode = 1;
            else
                mode = $urandom_range(2);
            span       = (made < 200) ? 100 : $urandom_range(120, 30);
            insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 55;
            repeat (span) begin
                if ($urandom_range(99) < insert_pct)
                    queue_cmd(CMD_INSERT, pick_key(),
                              INDEX_W'($urandom_range(HEAP_DEPTH - 1)),
                              first_random || ($urandom_range(99) == 0));
                else
                    queue_cmd(CMD_REMOVE, $urandom, pick_pos(shadow_size),
                              first_random || ($urandom_range(99) == 0));
                first_random = 1'b0;
                made++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_cmds.size() != 0 || start)
            @(posedge i_clk);
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Covered %0d commands (%0d inserts, %0d removes), %0d reports checked, peak %0d",
                 taken_count, insert_count, remove_count, report_count, peak_size);
        $display("Statuses seen: ok %0d, empty %0d, bad index %0d, full %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BAD_INDEX],
                 status_hits[ST_FULL]);
        if (error_count == 0)
            $display("tb_min_heap_priority_queue_top passed");
        else
            $display("tb_min_heap_priority_queue_top failed");
        $finish;
    end

    // Drive command beats: hold while busy, idle at random, pause for a drain when asked
    always @(posedge i_clk) begin : cmd_driver
        bit        idle_ok;
        t_heap_cmd item;
        idle_ok = !(taken_count >= 300 && taken_count < 500);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the beat until the block takes it
        end else if (drain_hold && (due_reports.size() != 0 || busy)) begin
            start <= 1'b0;
        end else begin
            drain_hold = 1'b0;
            if (queued_cmds.size() == 0) begin
                start <= 1'b0;
            end else if (queued_cmds[0].drain_first) begin
                queued_cmds[0].drain_first = 1'b0;
                drain_hold                 = 1'b1;
                start <= 1'b0;
            end else if (idle_ok && $urandom_range(99) < IDLE_PCT) begin
                start <= 1'b0;
            end else begin
                item = queued_cmds.pop_front();
                start          <= 1'b1;
                i_command      <= item.cmd;
                i_value        <= item.key;
                i_remove_index <= item.pos;
            end
        end
    end

    // Check each result beat, then record the command taken at this edge
    always @(posedge i_clk) begin : report_monitor
        t_heap_report want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (due_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing outstanding, expected none, got status %0d",
                             $time, o_status);
                end else begin
                    want = due_reports.pop_front();
                    report_count++;
                    if (o_status !== want.status) begin
                        error_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_status);
                    end
                    if (o_entry_count_out !== want.count) begin
                        error_count++;
                        $display("%0t: entry count mismatch, expected %0d, got %0d",
                                 $time, want.count, o_entry_count_out);
                    end
                    if (o_min_value !== want.min_value) begin
                        error_count++;
                        $display("%0t: min value mismatch, expected %0d, got %0d", $time,
                                 $signed(want.min_value), $signed(o_min_value));
                    end
                    if (o_min_valid !== want.min_valid) begin
                        error_count++;
                        $display("%0t: min valid mismatch, expected %0b, got %0b",
                                 $time, want.min_valid, o_min_valid);
                    end
                end
            end
            if (start && !busy) begin
                want = heap_apply_command(t_cmd'(i_command), i_value, i_remove_index);
                due_reports.push_back(want);
                taken_count++;
                status_hits[want.status]++;
                if (t_cmd'(i_command) == CMD_INSERT)
                    insert_count++;
                else
                    remove_count++;
                if (heap_size > peak_size)
                    peak_size = heap_size;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached, %0d reports outstanding",
                     $time, RUN_LIMIT, due_reports.size());
            $display("tb_min_heap_priority_queue_top failed");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/mhpq_seq.sv
src/min_heap_priority_queue_top.sv
dv/tb_min_heap_priority_queue_top.sv
